/* hw/rtl/assert_macros.svh */
// assertion macros included by the filter top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst, prop, msg)

`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* hw/rtl/ahdf_pkg.sv */
// constants and helpers for the alphanumeric history dedup filter
package ahdf_pkg;

   localparam int HISTORY_MAX_DEF = 16;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int BYTE_W          = 8;
   localparam int DEPTH_W         = 5;

   function automatic logic is_alnum(input logic [BYTE_W-1:0] b);
      logic digit;
      logic upper;
      logic lower;
      digit = (b >= 8'h30) && (b <= 8'h39);
      upper = (b >= 8'h41) && (b <= 8'h5A);
      lower = (b >= 8'h61) && (b <= 8'h7A);
      return digit || upper || lower;
   endfunction

endpackage

/* hw/rtl/alnum_history_dedup_filter_top.sv */
// alphanumeric byte filter with first-in-first-out duplicate history
// registers: input stage, then result stage; one parallel history compare lies between them
// throughput: one word per cycle while the result stage is not held by rsp_stall
// reset: synchronous, active high; clears history valid bits, ring pointer, fill level,
// count, pipeline valids and sets the depth register to zero
`include "assert_macros.svh"

module alnum_history_dedup_filter_top
   import ahdf_pkg::*;
#(
   parameter int HISTORY_MAX = HISTORY_MAX_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [DEPTH_W-1:0]    csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic                  req_block_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_emit_valid,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic [COUNT_BITS-1:0] rsp_emitted_count,
   output logic                  rsp_last_of_block
);

   localparam int IDX_W  = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
   localparam int FILL_W = $clog2(HISTORY_MAX + 1);
   localparam int SUM_W  = IDX_W + 1;
   localparam int CMP_W  = (FILL_W > DEPTH_W) ? FILL_W : DEPTH_W;

   // configuration
   logic [DEPTH_W-1:0] depth_ff;

   // input stage
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_end_ff;

   // history state
   logic [BYTE_W-1:0] hist_byte_ff [HISTORY_MAX];
   logic [BYTE_W-1:0] hist_byte_in [HISTORY_MAX];
   logic [HISTORY_MAX-1:0] hist_valid_ff, hist_valid_in;
   logic [IDX_W-1:0]  oldest_ff, oldest_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // result stage
   logic                  rsp_valid_ff;
   logic                  rsp_emit_ff;
   logic [BYTE_W-1:0]     rsp_byte_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_last_ff;

   logic              out_load;
   logic              advance;
   logic [CMP_W-1:0]  depth_eff;
   logic              hit;
   logic              alnum;
   logic              emit;
   logic              add_entry;
   logic [SUM_W-1:0]  app_sum;
   logic [SUM_W-1:0]  inc_sum;
   logic [IDX_W-1:0]  wr_pos;
   logic [COUNT_BITS-1:0] count_inc;

   assign csr_ready = 1'b1;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_load;
   assign req_stall = s1_valid_ff && !out_load;

   always_comb begin
      depth_eff = (CMP_W'(depth_ff) > CMP_W'(HISTORY_MAX)) ? CMP_W'(HISTORY_MAX)
                                                            : CMP_W'(depth_ff);
      alnum = is_alnum(s1_byte_ff);
      hit = 1'b0;
      for (int i = 0; i < HISTORY_MAX; i++) begin
         if (hist_valid_ff[i] && (hist_byte_ff[i] == s1_byte_ff)) begin
            hit = 1'b1;
         end
      end
      emit      = alnum && ((depth_eff == '0) || !hit);
      add_entry = alnum && (depth_eff != '0) && !hit;

      app_sum = SUM_W'(oldest_ff) + SUM_W'(fill_ff);
      if (app_sum >= SUM_W'(HISTORY_MAX)) begin
         app_sum = app_sum - SUM_W'(HISTORY_MAX);
      end
      inc_sum = SUM_W'(oldest_ff) + SUM_W'(1);
      if (inc_sum >= SUM_W'(HISTORY_MAX)) begin
         inc_sum = inc_sum - SUM_W'(HISTORY_MAX);
      end

      count_inc = count_ff;
      if (emit && (count_ff != '1)) begin
         count_inc = count_ff + COUNT_BITS'(1);
      end

      hist_byte_in  = hist_byte_ff;
      hist_valid_in = hist_valid_ff;
      oldest_in     = oldest_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      wr_pos        = oldest_ff;

      if (advance) begin
         if (add_entry) begin
            if (CMP_W'(fill_ff) < depth_eff) begin
               wr_pos  = app_sum[IDX_W-1:0];
               fill_in = fill_ff + FILL_W'(1);
            end else begin
               wr_pos    = oldest_ff;
               oldest_in = inc_sum[IDX_W-1:0];
            end
            hist_byte_in[wr_pos]  = s1_byte_ff;
            hist_valid_in[wr_pos] = 1'b1;
         end
         count_in = count_inc;
         if (s1_end_ff) begin
            hist_valid_in = '0;
            oldest_in     = '0;
            fill_in       = '0;
            count_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         hist_valid_ff <= '0;
         oldest_ff     <= '0;
         fill_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            depth_ff <= csr_wdata;
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         hist_valid_ff <= hist_valid_in;
         oldest_ff     <= oldest_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         if (out_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      hist_byte_ff <= hist_byte_in;
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_data_byte;
         s1_end_ff  <= req_block_end;
      end
      if (advance) begin
         rsp_emit_ff  <= emit;
         rsp_byte_ff  <= emit ? s1_byte_ff : '0;
         rsp_count_ff <= count_inc;
         rsp_last_ff  <= s1_end_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_emit_valid    = rsp_emit_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_emitted_count = rsp_count_ff;
   assign rsp_last_of_block = rsp_last_ff;

   `ASSERT_RST(a_fill_bound, clock, reset,
      FILL_W'(HISTORY_MAX) >= fill_ff, "fill level above history size")
   `ASSERT_RST(a_emit_counts, clock, reset,
      (rsp_valid_ff && rsp_emit_ff) |-> (rsp_count_ff != '0), "emitted word with zero count")
   `ASSERT_RST(a_drop_zero_byte, clock, reset,
      (rsp_valid_ff && !rsp_emit_ff) |-> (rsp_byte_ff == '0), "dropped word carries a byte")
   `ASSERT_RST(a_accept_loads, clock, reset,
      (req_valid && !req_stall) |=> s1_valid_ff, "accepted word not held in input stage")

endmodule
